[hw/rtl/lfys_pkg.sv]
`default_nettype none

package lfys_pkg;

  // tick divider for the line decision
  localparam int LineDivideDefault = 4;

  // datapath widths
  localparam int RateW  = 16;
  localparam int SensW  = 6;
  localparam int PwmW   = 13;
  localparam int DriveW = 14;
  localparam int SpeedW = 4;
  localparam int CfgIdxW = 3;

  // pd clamp limit
  localparam int PwmLimit = 7000;

  // fixed turn drive magnitudes
  localparam logic signed [DriveW-1:0] DriveSlow = 14'sd5000;
  localparam logic signed [DriveW-1:0] DriveMid  = 14'sd6000;
  localparam logic signed [DriveW-1:0] DriveHard = 14'sd7000;

  // turn modes, 0 is pd control
  typedef enum logic [2:0] {
    TURN_PD = 3'd0,
    TURN_L1 = 3'd1,
    TURN_R1 = 3'd2,
    TURN_L2 = 3'd3,
    TURN_R2 = 3'd4,
    TURN_L3 = 3'd5,
    TURN_R3 = 3'd6
  } turn_mode_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINE_EN  = 3'd0,
    CFG_RATE_GN  = 3'd1,
    CFG_DAMP_GN  = 3'd2,
    CFG_TARGET   = 3'd3
  } cfg_reg_e;

  // speed requests
  localparam logic signed [SpeedW-1:0] SpeedFast     = 4'sd3;
  localparam logic signed [SpeedW-1:0] SpeedStop     = 4'sd0;
  localparam logic signed [SpeedW-1:0] SpeedBack     = -4'sd1;
  localparam logic signed [SpeedW-1:0] SpeedStraight = 4'sd4;

endpackage

`default_nettype wire

[hw/rtl/lfys_drive.sv]
`default_nettype none

module lfys_drive (
  input  logic signed [lfys_pkg::RateW-1:0] yaw_i,
  input  logic signed [lfys_pkg::RateW-1:0] target_i,
  input  logic signed [lfys_pkg::RateW-1:0] last_i,
  input  logic signed [lfys_pkg::RateW-1:0] rate_gain_i,
  input  logic signed [lfys_pkg::RateW-1:0] damping_gain_i,
  input  lfys_pkg::turn_mode_e              turn_i,
  input  logic                              running_i,
  output logic [lfys_pkg::PwmW-1:0]         pwm_duty_o,
  output logic                              drive_pos_o,
  output logic                              drive_neg_o
);
  import lfys_pkg::*;

  localparam int ErrW  = RateW + 1;
  localparam int ProdW = RateW + ErrW;
  localparam int SumW  = ProdW + 1;

  logic signed [ErrW-1:0]   err_p, err_d;
  logic signed [ProdW-1:0]  prod_p, prod_d;
  logic signed [SumW-1:0]   sum, biased, quot, clamped;
  logic signed [DriveW-1:0] drive_pd, drive;
  logic signed [DriveW-1:0] drive_neg_val;

  // rate error and rate change
  assign err_p = {yaw_i[RateW-1], yaw_i} - {target_i[RateW-1], target_i};
  assign err_d = {yaw_i[RateW-1], yaw_i} - {last_i[RateW-1], last_i};

  // two q8.8 products in parallel
  assign prod_p = ProdW'(rate_gain_i) * ProdW'(err_p);
  assign prod_d = ProdW'(damping_gain_i) * ProdW'(err_d);
  assign sum    = {prod_p[ProdW-1], prod_p} + {prod_d[ProdW-1], prod_d};

  // divide by 256 truncating toward zero
  assign biased = sum + (sum[SumW-1] ? SumW'(255) : SumW'(0));
  assign quot   = biased >>> 8;

  // clamp to the pwm limit
  always_comb begin
    if (quot > SumW'(PwmLimit)) begin
      clamped = SumW'(PwmLimit);
    end else if (quot < -SumW'(PwmLimit)) begin
      clamped = -SumW'(PwmLimit);
    end else begin
      clamped = quot;
    end
  end
  assign drive_pd = DriveW'(clamped);

  // fixed turn override
  always_comb begin
    case (turn_i)
      TURN_L1: drive = -DriveSlow;
      TURN_R1: drive = DriveSlow;
      TURN_L2: drive = -DriveMid;
      TURN_R2: drive = DriveMid;
      TURN_L3: drive = -DriveHard;
      TURN_R3: drive = DriveHard;
      default: drive = drive_pd;
    endcase
  end

  // sign-magnitude output, off when not running
  assign drive_neg_val = -drive;
  always_comb begin
    pwm_duty_o  = '0;
    drive_pos_o = 1'b0;
    drive_neg_o = 1'b0;
    if (running_i) begin
      if (drive[DriveW-1]) begin
        pwm_duty_o  = PwmW'(drive_neg_val);
        drive_neg_o = 1'b1;
      end else begin
        pwm_duty_o  = PwmW'(drive);
        drive_pos_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/line_follow_yaw_steering.sv]
`default_nettype none

// channel | signals                          | payload
// --------+----------------------------------+-----------------------------
// in      | in_valid_i / in_stall_o          | yaw_rate, line_sensors, running
// out     | out_valid_o / out_stall_i        | pwm_duty, drive_pos/neg, speed, turn
// cfg     | cfg_valid_i / cfg_ready_o        | cfg_index_i, cfg_data_i
//
// one transaction per clock cycle sustained while the output is not stalled; each
// input passes through the input register, then the result register.
// the multiply, add, clamp and override path sits between those two registers.
// reset clears the tick phase, held turn/speed, last rate, the valid flags and the
// cfg registers (rate gain resets to 30.0 in q8.8); stall on the output holds
// the result and backs up into in_stall_o once the input register is also full.

module line_follow_yaw_steering #(
  parameter int LINE_DIVIDE = lfys_pkg::LineDivideDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lfys_pkg::RateW-1:0]   yaw_rate_i,
  input  logic [lfys_pkg::SensW-1:0]          line_sensors_i,
  input  logic                                running_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lfys_pkg::PwmW-1:0]           pwm_duty_o,
  output logic                                drive_pos_o,
  output logic                                drive_neg_o,
  output logic signed [lfys_pkg::SpeedW-1:0]  speed_request_o,
  output logic [2:0]                          turn_mode_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lfys_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lfys_pkg::RateW-1:0]          cfg_data_i
);
  import lfys_pkg::*;

  localparam int PhaseW = (LINE_DIVIDE > 1) ? $clog2(LINE_DIVIDE) : 1;
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(LINE_DIVIDE - 1);

  // configuration registers
  logic                     line_en_q;
  logic signed [RateW-1:0]  rate_gain_q, damping_gain_q, target_q;

  // controller state
  logic signed [RateW-1:0]  last_rate_q;
  turn_mode_e               turn_q, turn_d;
  logic signed [SpeedW-1:0] speed_q, speed_d;
  logic [PhaseW-1:0]        phase_q, phase_d;
  logic                     clear_target;
  logic signed [RateW-1:0]  target_eff;

  // input register
  logic                     s1_valid_q;
  logic signed [RateW-1:0]  s1_yaw_q;
  logic [SensW-1:0]         s1_sens_q;
  logic                     s1_run_q;

  // result register
  logic                     out_valid_q;
  logic [PwmW-1:0]          pwm_q, pwm_d;
  logic                     pos_q, pos_d, neg_q, neg_d;
  logic signed [SpeedW-1:0] speed_out_q;
  turn_mode_e               turn_out_q;

  logic res_ready, advance, in_accept, cfg_write;

  // handshake
  assign res_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && res_ready;
  assign in_stall_o = s1_valid_q && !res_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // tick phase and line decision
  always_comb begin
    phase_d      = phase_q + PhaseW'(1);
    turn_d       = turn_q;
    speed_d      = speed_q;
    clear_target = 1'b0;
    if (phase_q == PhaseLast) begin
      phase_d = '0;
      speed_d = SpeedStop;
      if (line_en_q) begin
        if (s1_sens_q[0]) begin
          turn_d = TURN_L1; speed_d = SpeedFast;
        end else if (s1_sens_q[3]) begin
          turn_d = TURN_R1; speed_d = SpeedFast;
        end else if (s1_sens_q[1]) begin
          turn_d = TURN_L2; speed_d = SpeedStop;
        end else if (s1_sens_q[4]) begin
          turn_d = TURN_R2; speed_d = SpeedStop;
        end else if (s1_sens_q[2]) begin
          turn_d = TURN_L3; speed_d = SpeedBack;
        end else if (s1_sens_q[5]) begin
          turn_d = TURN_R3; speed_d = SpeedBack;
        end else begin
          turn_d = TURN_PD; speed_d = SpeedStraight; clear_target = 1'b1;
        end
      end
    end
  end

  assign target_eff = clear_target ? '0 : target_q;

  // pd term, override and pwm encoding
  lfys_drive u_drive (
    .yaw_i          (s1_yaw_q),
    .target_i       (target_eff),
    .last_i         (last_rate_q),
    .rate_gain_i    (rate_gain_q),
    .damping_gain_i (damping_gain_q),
    .turn_i         (turn_d),
    .running_i      (s1_run_q),
    .pwm_duty_o     (pwm_d),
    .drive_pos_o    (pos_d),
    .drive_neg_o    (neg_d)
  );

  // configuration writes and target clear from the decision
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_en_q      <= 1'b0;
      rate_gain_q    <= 16'sd7680;
      damping_gain_q <= '0;
      target_q       <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index_i)
          CFG_LINE_EN: line_en_q      <= cfg_data_i[0];
          CFG_RATE_GN: rate_gain_q    <= cfg_data_i;
          CFG_DAMP_GN: damping_gain_q <= cfg_data_i;
          CFG_TARGET:  target_q       <= cfg_data_i;
          default: ;
        endcase
      end else if (advance && clear_target) begin
        target_q <= '0;
      end
    end
  end

  // controller state updates as each item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rate_q <= '0;
      turn_q      <= TURN_PD;
      speed_q     <= '0;
      phase_q     <= '0;
    end else if (advance) begin
      last_rate_q <= s1_yaw_q;
      turn_q      <= turn_d;
      speed_q     <= speed_d;
      phase_q     <= phase_d;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_yaw_q  <= yaw_rate_i;
      s1_sens_q <= line_sensors_i;
      s1_run_q  <= running_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pwm_q       <= pwm_d;
      pos_q       <= pos_d;
      neg_q       <= neg_d;
      speed_out_q <= speed_d;
      turn_out_q  <= turn_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pwm_duty_o      = pwm_q;
  assign drive_pos_o     = pos_q;
  assign drive_neg_o     = neg_q;
  assign speed_request_o = speed_out_q;
  assign turn_mode_o     = turn_out_q;

endmodule

`default_nettype wire
